### design/ctc_pkg.sv
// ============================================================================
// ctc_pkg - shared constants for the contactor trip controller
// Widths, reset values and register indexes used by the controller and its
// port checker.
// ============================================================================
package ctc_pkg;

   // default widths of the current path
   localparam int SAMPLE_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF   = 16;

   // fixed field widths
   localparam int TRIP_BITS  = 12;
   localparam int COEF_BITS  = 16;
   localparam int SCALE_BITS = 10;
   localparam int AUX_BITS   = 22;

   // multiplier digit handling: 4 bits of the coefficient per cycle
   localparam int DIGIT_BITS = 4;
   localparam int DIGITS     = COEF_BITS / DIGIT_BITS;
   localparam int CNT_BITS   = $clog2(DIGITS);

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_TRIP_HIGH     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TRIP_LOW      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CURRENT_ALPHA = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_AUX_ALPHA     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_AUX_SCALE     = 3'd4;

   // register reset values
   localparam logic [TRIP_BITS-1:0]  TRIP_HIGH_RST     = 12'd3500;
   localparam logic [TRIP_BITS-1:0]  TRIP_LOW_RST      = 12'd700;
   localparam logic [COEF_BITS-1:0]  CURRENT_ALPHA_RST = 16'd206;
   localparam logic [COEF_BITS-1:0]  AUX_ALPHA_RST     = 16'd3991;
   localparam logic [SCALE_BITS-1:0] AUX_SCALE_RST     = 10'd290;

   // operation codes
   localparam logic OP_CURRENT = 1'b0;
   localparam logic OP_TICK    = 1'b1;

endpackage

### design/contactor_trip_controller_unit.sv
// ============================================================================
// contactor_trip_controller_unit - battery contactor guard
// Current samples run a one-pole low-pass filter and a trip window; control
// ticks filter the scaled auxiliary voltage and apply the key-switch rules.
// ============================================================================
// Sequence: a current sample runs the blend passes, round and push; a control
//   tick runs the scale passes, prep, the blend passes, round and push.
// One transaction at a time: requests stall until the result is registered;
//   the single 4-bit-digit multiplier makes 4 passes per multiplication.
// Reset: synchronous, active high; filters, contactor, fault and heartbeat
//   clear and the configuration registers take their default values.
module contactor_trip_controller_unit
   import ctc_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_operation,
   input  logic [SAMPLE_BITS-1:0]          req_current_sample,
   input  logic [SAMPLE_BITS-1:0]          req_aux_sample,
   input  logic                            req_key_switch,
   input  logic                            req_discharged_flag,
   input  logic                            req_temp_flag,
   input  logic                            req_charger_active,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [SAMPLE_BITS+FRAC_BITS-1:0] rsp_filtered_current,
   output logic [AUX_BITS-1:0]             rsp_aux_voltage,
   output logic                            rsp_contactor_closed,
   output logic                            rsp_current_fault,
   output logic                            rsp_heartbeat,
   // configuration write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]        csr_wdata
);

   // filter width, signed difference width and accumulator width
   localparam int CW = SAMPLE_BITS + FRAC_BITS;
   localparam int MW = ((CW > AUX_BITS) ? CW : AUX_BITS) + 1;
   localparam int AW = MW + COEF_BITS + 1;
   localparam int TW = (SAMPLE_BITS > TRIP_BITS) ? SAMPLE_BITS : TRIP_BITS;

   localparam logic signed [AW-1:0] RND_HALF = AW'(1 << (COEF_BITS - 1));
   localparam logic signed [AW-1:0] AUX_SAT  = AW'((1 << AUX_BITS) - 1);
   localparam logic [CNT_BITS-1:0]  CNT_LAST = CNT_BITS'(DIGITS - 1);

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,   // waiting for a transaction
      ST_SCALE = 6'b000010,   // aux sample times aux scale
      ST_PREP  = 6'b000100,   // saturate the scaled sample, form the difference
      ST_BLEND = 6'b001000,   // difference times filter coefficient
      ST_ROUND = 6'b010000,   // round, update filter and flags
      ST_PUSH  = 6'b100000    // hand the state to the response register
   } ctc_state_type;

   ctc_state_type state_ff, state_in;

   // configuration registers
   logic [TRIP_BITS-1:0]  trip_high_ff, trip_high_in;
   logic [TRIP_BITS-1:0]  trip_low_ff, trip_low_in;
   logic [COEF_BITS-1:0]  current_alpha_ff, current_alpha_in;
   logic [COEF_BITS-1:0]  aux_alpha_ff, aux_alpha_in;
   logic [SCALE_BITS-1:0] aux_scale_ff, aux_scale_in;

   // architectural state
   logic [CW-1:0]       cur_filter_ff, cur_filter_in;
   logic [AUX_BITS-1:0] aux_filter_ff, aux_filter_in;
   logic                contactor_ff, contactor_in;
   logic                fault_ff, fault_in;
   logic                heartbeat_ff, heartbeat_in;

   // captured transaction
   logic                   op_ff, op_in;
   logic [SAMPLE_BITS-1:0] cur_s_ff, cur_s_in;
   logic                   key_ff, key_in;
   logic                   dis_ff, dis_in;
   logic                   tmp_ff, tmp_in;
   logic                   chg_ff, chg_in;

   // shared multiplier: MSB-first, one coefficient digit per cycle
   logic signed [MW-1:0] mcand_ff, mcand_in;
   logic [COEF_BITS-1:0] mplier_ff, mplier_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]       rsp_cur_ff, rsp_cur_in;
   logic [AUX_BITS-1:0] rsp_aux_ff, rsp_aux_in;
   logic                rsp_cont_ff, rsp_cont_in;
   logic                rsp_fault_ff, rsp_fault_in;
   logic                rsp_hb_ff, rsp_hb_in;

   // datapath nets
   logic [DIGIT_BITS-1:0] digit;
   logic signed [AW-1:0]  partial;
   logic signed [AW-1:0]  step_sum;
   logic signed [AW-1:0]  rounded;
   logic signed [AW-1:0]  quotient;
   logic [AUX_BITS-1:0]   aux_x;
   logic [CW-1:0]         cur_x;
   logic [TW-1:0]         s_ext;
   logic                  trip;
   logic                  req_take;
   logic                  rsp_load;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // one multiply-accumulate step of the shared unit
   assign digit    = mplier_ff[COEF_BITS-1 -: DIGIT_BITS];
   assign partial  = AW'(mcand_ff) * AW'($signed({1'b0, digit}));
   assign step_sum = (acc_ff <<< DIGIT_BITS) + partial;

   // round to nearest, ties upward; floor shift of the signed product
   assign rounded  = acc_ff + RND_HALF;
   assign quotient = rounded >>> COEF_BITS;

   // saturated scaled auxiliary sample
   assign aux_x = (acc_ff > AUX_SAT) ? AUX_BITS'((1 << AUX_BITS) - 1)
                                     : acc_ff[AUX_BITS-1:0];

   assign cur_x = {req_current_sample, {FRAC_BITS{1'b0}}};

   // trip window test on the raw sample
   assign s_ext = TW'(cur_s_ff);
   assign trip  = (s_ext > TW'(trip_high_ff)) || (s_ext < TW'(trip_low_ff));

   // response register frees up when empty or when its transaction leaves
   assign rsp_load = (state_ff == ST_PUSH) && (!rsp_valid_ff || !rsp_stall);

   // configuration writes
   always_comb begin
      trip_high_in     = trip_high_ff;
      trip_low_in      = trip_low_ff;
      current_alpha_in = current_alpha_ff;
      aux_alpha_in     = aux_alpha_ff;
      aux_scale_in     = aux_scale_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TRIP_HIGH:     trip_high_in     = csr_wdata[TRIP_BITS-1:0];
            REG_TRIP_LOW:      trip_low_in      = csr_wdata[TRIP_BITS-1:0];
            REG_CURRENT_ALPHA: current_alpha_in = csr_wdata[COEF_BITS-1:0];
            REG_AUX_ALPHA:     aux_alpha_in     = csr_wdata[COEF_BITS-1:0];
            REG_AUX_SCALE:     aux_scale_in     = csr_wdata[SCALE_BITS-1:0];
            default: ;   // drop writes to unknown indexes
         endcase
      end
   end

   // sequencer and datapath
   always_comb begin
      state_in      = state_ff;
      cur_filter_in = cur_filter_ff;
      aux_filter_in = aux_filter_ff;
      contactor_in  = contactor_ff;
      fault_in      = fault_ff;
      heartbeat_in  = heartbeat_ff;
      op_in         = op_ff;
      cur_s_in      = cur_s_ff;
      key_in        = key_ff;
      dis_in        = dis_ff;
      tmp_in        = tmp_ff;
      chg_in        = chg_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_in    = req_operation;
               cur_s_in = req_current_sample;
               key_in   = req_key_switch;
               dis_in   = req_discharged_flag;
               tmp_in   = req_temp_flag;
               chg_in   = req_charger_active;
               acc_in   = '0;
               cnt_in   = '0;
               if (req_operation == OP_CURRENT) begin
                  // blend directly: (x - y) * alpha
                  mcand_in  = MW'($signed({1'b0, cur_x}))
                            - MW'($signed({1'b0, cur_filter_ff}));
                  mplier_in = current_alpha_ff;
                  state_in  = ST_BLEND;
               end else begin
                  // scale the aux sample first
                  mcand_in  = MW'($signed({1'b0, req_aux_sample}));
                  mplier_in = {{(COEF_BITS - SCALE_BITS){1'b0}}, aux_scale_ff};
                  state_in  = ST_SCALE;
               end
            end
         end
         ST_SCALE: begin
            acc_in    = step_sum;
            mplier_in = mplier_ff << DIGIT_BITS;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            mcand_in  = MW'($signed({1'b0, aux_x}))
                      - MW'($signed({1'b0, aux_filter_ff}));
            mplier_in = aux_alpha_ff;
            acc_in    = '0;
            cnt_in    = '0;
            state_in  = ST_BLEND;
         end
         ST_BLEND: begin
            acc_in    = step_sum;
            mplier_in = mplier_ff << DIGIT_BITS;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (op_ff == OP_CURRENT) begin
               cur_filter_in = cur_filter_ff + quotient[CW-1:0];
               if (trip) begin
                  contactor_in = 1'b0;
                  fault_in     = 1'b1;
               end
               heartbeat_in = !heartbeat_ff;
            end else begin
               aux_filter_in = aux_filter_ff + quotient[AUX_BITS-1:0];
               if (key_ff) begin
                  if (!dis_ff && !fault_ff && !tmp_ff && !chg_ff) begin
                     contactor_in = 1'b1;
                  end
               end else if (!chg_ff) begin
                  fault_in     = 1'b0;
                  contactor_in = 1'b0;
               end
            end
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response register: load the updated state, clear when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_cur_in   = rsp_cur_ff;
      rsp_aux_in   = rsp_aux_ff;
      rsp_cont_in  = rsp_cont_ff;
      rsp_fault_in = rsp_fault_ff;
      rsp_hb_in    = rsp_hb_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_cur_in   = cur_filter_ff;
         rsp_aux_in   = aux_filter_ff;
         rsp_cont_in  = contactor_ff;
         rsp_fault_in = fault_ff;
         rsp_hb_in    = heartbeat_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         trip_high_ff     <= TRIP_HIGH_RST;
         trip_low_ff      <= TRIP_LOW_RST;
         current_alpha_ff <= CURRENT_ALPHA_RST;
         aux_alpha_ff     <= AUX_ALPHA_RST;
         aux_scale_ff     <= AUX_SCALE_RST;
         cur_filter_ff    <= '0;
         aux_filter_ff    <= '0;
         contactor_ff     <= 1'b0;
         fault_ff         <= 1'b0;
         heartbeat_ff     <= 1'b0;
         cnt_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         trip_high_ff     <= trip_high_in;
         trip_low_ff      <= trip_low_in;
         current_alpha_ff <= current_alpha_in;
         aux_alpha_ff     <= aux_alpha_in;
         aux_scale_ff     <= aux_scale_in;
         cur_filter_ff    <= cur_filter_in;
         aux_filter_ff    <= aux_filter_in;
         contactor_ff     <= contactor_in;
         fault_ff         <= fault_in;
         heartbeat_ff     <= heartbeat_in;
         cnt_ff           <= cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      cur_s_ff     <= cur_s_in;
      key_ff       <= key_in;
      dis_ff       <= dis_in;
      tmp_ff       <= tmp_in;
      chg_ff       <= chg_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      acc_ff       <= acc_in;
      rsp_cur_ff   <= rsp_cur_in;
      rsp_aux_ff   <= rsp_aux_in;
      rsp_cont_ff  <= rsp_cont_in;
      rsp_fault_ff <= rsp_fault_in;
      rsp_hb_ff    <= rsp_hb_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_filtered_current = rsp_cur_ff;
   assign rsp_aux_voltage      = rsp_aux_ff;
   assign rsp_contactor_closed = rsp_cont_ff;
   assign rsp_current_fault    = rsp_fault_ff;
   assign rsp_heartbeat        = rsp_hb_ff;

endmodule

### design/ctc_checker.sv
// ============================================================================
// ctc_checker - port-level checks for the contactor trip controller
// Watches the request and response channels over time.
// ============================================================================
module ctc_checker
   import ctc_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [SAMPLE_BITS+FRAC_BITS-1:0] rsp_filtered_current,
   input logic [AUX_BITS-1:0]              rsp_aux_voltage,
   input logic                             rsp_contactor_closed,
   input logic                             rsp_current_fault,
   input logic                             rsp_heartbeat
);

   // the request side stays stalled after taking a transaction
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall ##1 req_stall)
      else $error("request taken again while the multiplier is busy");

   // a latched fault always goes with an open contactor
   a_fault_opens: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_contactor_closed && rsp_current_fault))
      else $error("contactor reported closed with a latched fault");

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_filtered_current)
         && $stable(rsp_aux_voltage) && $stable(rsp_contactor_closed)
         && $stable(rsp_current_fault) && $stable(rsp_heartbeat))
      else $error("stalled response payload changed");

endmodule

bind contactor_trip_controller_unit ctc_checker #(
   .SAMPLE_BITS(SAMPLE_BITS),
   .FRAC_BITS  (FRAC_BITS)
) u_ctc_checker (.*);

### test/contactor_trip_controller_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// contactor_trip_controller_checker - status predictor and result comparator
// Mirrors the filter, trip and key-switch state of the controller from the
// accepted requests and register writes, and compares every accepted result
// with the oldest predicted status.
// ============================================================================
module contactor_trip_controller_checker
   import ctc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic                        req_operation,
   input  logic [SAMPLE_BITS_DEF-1:0]  req_current_sample,
   input  logic [SAMPLE_BITS_DEF-1:0]  req_aux_sample,
   input  logic                        req_key_switch,
   input  logic                        req_discharged_flag,
   input  logic                        req_temp_flag,
   input  logic                        req_charger_active,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [SAMPLE_BITS_DEF+FRAC_BITS_DEF-1:0] rsp_filtered_current,
   input  logic [AUX_BITS-1:0]         rsp_aux_voltage,
   input  logic                        rsp_contactor_closed,
   input  logic                        rsp_current_fault,
   input  logic                        rsp_heartbeat,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]    csr_wdata,
   output int                          mismatch_count,
   output int                          pending_count
);

   localparam int CUR_BITS = SAMPLE_BITS_DEF + FRAC_BITS_DEF;
   localparam logic [63:0] AUX_MAX = (64'd1 << AUX_BITS) - 64'd1;

   typedef struct packed {
      logic [CUR_BITS-1:0] filtered_current;
      logic [AUX_BITS-1:0] aux_voltage;
      logic                contactor_closed;
      logic                current_fault;
      logic                heartbeat;
   } status_type;

   logic [TRIP_BITS-1:0]  trip_high_q;
   logic [TRIP_BITS-1:0]  trip_low_q;
   logic [COEF_BITS-1:0]  cur_alpha_q;
   logic [COEF_BITS-1:0]  aux_alpha_q;
   logic [SCALE_BITS-1:0] aux_scale_q;
   status_type            status_q;
   status_type            predicted_status_q[$];
   int                    errors = 0;

   // one-pole blend in Q16, rounded to nearest with ties upward
   function automatic logic [63:0] low_pass(input logic [63:0] prev,
                                            input logic [63:0] target,
                                            input logic [COEF_BITS-1:0] alpha);
      logic [63:0] one;
      logic [63:0] acc;
      one = 64'd1 << COEF_BITS;
      acc = prev * (one - {48'd0, alpha}) + target * {48'd0, alpha} + (one >> 1);
      return acc >> COEF_BITS;
   endfunction

   function automatic status_type next_status(input status_type s,
                                              input logic op,
                                              input logic [SAMPLE_BITS_DEF-1:0] amps,
                                              input logic [SAMPLE_BITS_DEF-1:0] volts_raw,
                                              input logic key, dis, hot, chg);
      status_type  n;
      logic [63:0] prev;
      logic [63:0] target;
      logic [63:0] blend;
      n = s;
      if (op == OP_CURRENT) begin
         prev   = {{(64-CUR_BITS){1'b0}}, s.filtered_current};
         target = {{(64-SAMPLE_BITS_DEF){1'b0}}, amps} << FRAC_BITS_DEF;
         blend  = low_pass(prev, target, cur_alpha_q);
         n.filtered_current = blend[CUR_BITS-1:0];
         if (amps > trip_high_q || amps < trip_low_q) begin
            n.contactor_closed = 1'b0;
            n.current_fault    = 1'b1;
         end
         n.heartbeat = ~s.heartbeat;
      end else begin
         target = {{(64-SAMPLE_BITS_DEF){1'b0}}, volts_raw} *
                  {{(64-SCALE_BITS){1'b0}}, aux_scale_q};
         if (target > AUX_MAX) target = AUX_MAX;
         prev  = {{(64-AUX_BITS){1'b0}}, s.aux_voltage};
         blend = low_pass(prev, target, aux_alpha_q);
         n.aux_voltage = blend[AUX_BITS-1:0];
         if (key) begin
            if (!dis && !s.current_fault && !hot && !chg) n.contactor_closed = 1'b1;
         end else if (!chg) begin
            n.current_fault    = 1'b0;
            n.contactor_closed = 1'b0;
         end
      end
      return n;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      status_type want;
      status_type got;
      if (reset) begin
         trip_high_q = TRIP_HIGH_RST;
         trip_low_q  = TRIP_LOW_RST;
         cur_alpha_q = CURRENT_ALPHA_RST;
         aux_alpha_q = AUX_ALPHA_RST;
         aux_scale_q = AUX_SCALE_RST;
         status_q    = '0;
         predicted_status_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TRIP_HIGH:     trip_high_q = csr_wdata[TRIP_BITS-1:0];
               REG_TRIP_LOW:      trip_low_q  = csr_wdata[TRIP_BITS-1:0];
               REG_CURRENT_ALPHA: cur_alpha_q = csr_wdata[COEF_BITS-1:0];
               REG_AUX_ALPHA:     aux_alpha_q = csr_wdata[COEF_BITS-1:0];
               REG_AUX_SCALE:     aux_scale_q = csr_wdata[SCALE_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_filtered_current, rsp_aux_voltage, rsp_contactor_closed,
                   rsp_current_fault, rsp_heartbeat};
            if (predicted_status_q.size() == 0) begin
               $display("%0t: unexpected result transaction, actual %h", $time, got);
               errors++;
            end else begin
               want = predicted_status_q.pop_front();
               check_field("filtered_current", 32'(want.filtered_current),
                           32'(got.filtered_current));
               check_field("aux_voltage", 32'(want.aux_voltage), 32'(got.aux_voltage));
               check_field("contactor_closed", 32'(want.contactor_closed),
                           32'(got.contactor_closed));
               check_field("current_fault", 32'(want.current_fault),
                           32'(got.current_fault));
               check_field("heartbeat", 32'(want.heartbeat), 32'(got.heartbeat));
            end
         end
         if (req_valid && !req_stall) begin
            status_q = next_status(status_q, req_operation, req_current_sample,
                                   req_aux_sample, req_key_switch, req_discharged_flag,
                                   req_temp_flag, req_charger_active);
            predicted_status_q.push_back(status_q);
         end
      end
      pending_count  <= predicted_status_q.size();
      mismatch_count <= errors;
   end

endmodule

### test/contactor_trip_controller_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// contactor_trip_controller_unit_test - contactor trip controller testbench
// Drives directed and random current-sample and tick transactions through
// several register settings with random gaps and output stalls; a separate
// checker predicts every result and counts mismatches.
// ============================================================================
module contactor_trip_controller_unit_test
   import ctc_pkg::*;
();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 200;  // long receiver hold-off to back up the block
   localparam int DRAIN_CYCLES = 20;   // beyond the longest transaction, a tick

   typedef struct packed {
      logic                       operation;
      logic [SAMPLE_BITS_DEF-1:0] current_sample;
      logic [SAMPLE_BITS_DEF-1:0] aux_sample;
      logic                       key_switch;
      logic                       discharged_flag;
      logic                       temp_flag;
      logic                       charger_active;
   } event_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic                        req_operation;
   logic [SAMPLE_BITS_DEF-1:0]  req_current_sample;
   logic [SAMPLE_BITS_DEF-1:0]  req_aux_sample;
   logic                        req_key_switch;
   logic                        req_discharged_flag;
   logic                        req_temp_flag;
   logic                        req_charger_active;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [SAMPLE_BITS_DEF+FRAC_BITS_DEF-1:0] rsp_filtered_current;
   logic [AUX_BITS-1:0]         rsp_aux_voltage;
   logic                        rsp_contactor_closed;
   logic                        rsp_current_fault;
   logic                        rsp_heartbeat;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]    csr_wdata;
   int                          mismatch_count;
   int                          pending_count;

   // stimulus shaping, owned by the stimulus process
   bit                          no_gaps = 1'b0;
   int unsigned                 holds_requested = 0;
   int unsigned                 holds_done = 0;
   logic [TRIP_BITS-1:0]        win_high = TRIP_HIGH_RST;
   logic [TRIP_BITS-1:0]        win_low  = TRIP_LOW_RST;

   contactor_trip_controller_unit u_dut (.*);

   contactor_trip_controller_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Bound the run; a hang anywhere ends here.
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   // Result side: draw a stall per transaction, or hold off for a long stretch
   // when the stimulus asks for it, so the block fills and stalls its input.
   initial begin : result_sink
      int unsigned pause;
      rsp_stall = 1'b0;
      forever begin
         if (holds_done != holds_requested) begin
            holds_done++;
            pause = HOLD_CYCLES;
         end else if (no_gaps) begin
            pause = 0;
         end else begin
            pause = $urandom_range(0, 9);
         end
         if (pause != 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         // stall is low from here on, so valid alone marks the transaction
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic event_type pack_event(input logic op,
                                            input logic [SAMPLE_BITS_DEF-1:0] amps,
                                            input logic [SAMPLE_BITS_DEF-1:0] volts,
                                            input logic key, dis, hot, chg);
      event_type e;
      e.operation       = op;
      e.current_sample  = amps;
      e.aux_sample      = volts;
      e.key_switch      = key;
      e.discharged_flag = dis;
      e.temp_flag       = hot;
      e.charger_active  = chg;
      return e;
   endfunction

   // Mostly samples in or at the edges of the trip window, the rest anywhere;
   // keys mostly on and flags mostly clear so the contactor gets to close.
   function automatic event_type random_event();
      event_type   e;
      logic [31:0] rnd;
      rnd = $urandom;
      e.operation = rnd[0] ? OP_TICK : OP_CURRENT;
      case ($urandom_range(0, 9))
         0: e.current_sample = win_high;
         1: e.current_sample = win_low;
         2: e.current_sample = win_high + 12'd1;
         3: e.current_sample = win_low - 12'd1;
         4, 5, 6: e.current_sample = rnd[27:16];
         default: begin
            if (win_low <= win_high)
               e.current_sample = 12'($urandom_range(win_low, win_high));
            else
               e.current_sample = rnd[27:16];
         end
      endcase
      case ($urandom_range(0, 7))
         0: e.aux_sample = '0;
         1: e.aux_sample = '1;
         default: e.aux_sample = rnd[12:1];
      endcase
      e.key_switch      = ($urandom_range(0, 3) != 0);
      e.discharged_flag = ($urandom_range(0, 4) == 0);
      e.temp_flag       = ($urandom_range(0, 4) == 0);
      e.charger_active  = ($urandom_range(0, 3) == 0);
      return e;
   endfunction

   // Offer one transaction after a random gap; valid stays high into the next
   // transaction when that one has no gap.
   task automatic offer_transaction(input event_type e);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_operation       <= e.operation;
      req_current_sample  <= e.current_sample;
      req_aux_sample      <= e.aux_sample;
      req_key_switch      <= e.key_switch;
      req_discharged_flag <= e.discharged_flag;
      req_temp_flag       <= e.temp_flag;
      req_charger_active  <= e.charger_active;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Leaves csr_valid high; the caller drops it after the last write.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Write every register, plus one index past the map that must be ignored.
   task automatic configure(input logic [CSR_DATA_BITS-1:0] high_word, low_word,
                            input logic [CSR_DATA_BITS-1:0] cur_coef, aux_coef,
                            input logic [CSR_DATA_BITS-1:0] scale_word);
      logic [CSR_INDEX_BITS-1:0] stray;
      logic [31:0]               rnd;
      rnd   = $urandom;
      stray = REG_AUX_SCALE + 3'd1 + {1'b0, rnd[17:16] % 2'd3};
      write_reg(REG_TRIP_HIGH, high_word);
      write_reg(REG_TRIP_LOW, low_word);
      write_reg(REG_CURRENT_ALPHA, cur_coef);
      write_reg(REG_AUX_ALPHA, aux_coef);
      write_reg(REG_AUX_SCALE, scale_word);
      write_reg(stray, rnd[15:0]);
      csr_valid <= 1'b0;
      win_high = high_word[TRIP_BITS-1:0];
      win_low  = low_word[TRIP_BITS-1:0];
   endtask

   task automatic configure_random();
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      a = $urandom;
      b = $urandom;
      c = $urandom;
      configure(a[15:0], a[31:16], b[15:0], b[31:16], c[15:0]);
   endtask

   task automatic run_phase(input int count, input bit burst, input bit squeeze);
      no_gaps = burst;
      if (squeeze) holds_requested++;
      repeat (count) offer_transaction(random_event());
      req_valid <= 1'b0;
      wait_drained();
      no_gaps = 1'b0;
   endtask

   initial begin : stimulus
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_operation       = OP_CURRENT;
      req_current_sample  = '0;
      req_aux_sample      = '0;
      req_key_switch      = 1'b0;
      req_discharged_flag = 1'b0;
      req_temp_flag       = 1'b0;
      req_charger_active  = 1'b0;
      csr_valid           = 1'b0;
      csr_index           = REG_TRIP_HIGH;
      csr_wdata           = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset settings: window 700..3500.
      offer_transaction(pack_event(OP_TICK, 12'd4095, 12'd4095, 1, 0, 0, 0)); // close
      offer_transaction(pack_event(OP_CURRENT, 12'd2048, 12'd0, 0, 0, 0, 0));
      offer_transaction(pack_event(OP_CURRENT, 12'd3500, 12'd0, 0, 0, 0, 0)); // at bounds
      offer_transaction(pack_event(OP_CURRENT, 12'd700, 12'd0, 0, 0, 0, 0));
      offer_transaction(pack_event(OP_CURRENT, 12'd3501, 12'd0, 0, 0, 0, 0)); // trip high
      offer_transaction(pack_event(OP_TICK, 12'd0, 12'd4095, 1, 0, 0, 0));    // fault blocks
      offer_transaction(pack_event(OP_TICK, 12'd0, 12'd2000, 0, 0, 0, 1));    // charging hold
      offer_transaction(pack_event(OP_TICK, 12'd0, 12'd0, 0, 0, 0, 0));       // clear fault
      offer_transaction(pack_event(OP_TICK, 12'd0, 12'd4095, 1, 1, 0, 0));    // discharged
      offer_transaction(pack_event(OP_TICK, 12'd0, 12'd4095, 1, 0, 1, 0));    // too hot
      offer_transaction(pack_event(OP_TICK, 12'd0, 12'd4095, 1, 0, 0, 1));    // charging
      offer_transaction(pack_event(OP_TICK, 12'd0, 12'd4095, 1, 0, 0, 0));    // close
      offer_transaction(pack_event(OP_CURRENT, 12'd699, 12'd0, 0, 0, 0, 0));  // trip low
      offer_transaction(pack_event(OP_CURRENT, 12'd0, 12'd0, 0, 0, 0, 0));
      offer_transaction(pack_event(OP_CURRENT, 12'd4095, 12'd0, 0, 0, 0, 0));
      offer_transaction(pack_event(OP_TICK, 12'd0, 12'd1234, 0, 0, 0, 0));
      offer_transaction(pack_event(OP_TICK, 12'd0, 12'd4095, 1, 0, 0, 0));
      // fields of the other event kind must be ignored
      offer_transaction(pack_event(OP_CURRENT, 12'd1000, 12'd4095, 0, 1, 1, 0));
      offer_transaction(pack_event(OP_TICK, 12'd4095, 12'd123, 1, 0, 0, 0));
      req_valid <= 1'b0;
      wait_drained();

      // Inverted window, zero coefficients hold both filters, widest scale.
      configure(16'd0, 16'd4095, 16'd0, 16'd0, 16'd1023);
      offer_transaction(pack_event(OP_CURRENT, 12'd2048, 12'd0, 0, 0, 0, 0));
      offer_transaction(pack_event(OP_TICK, 12'd0, 12'd4095, 1, 0, 0, 0));
      offer_transaction(pack_event(OP_TICK, 12'd0, 12'd4095, 0, 0, 0, 0));
      offer_transaction(pack_event(OP_TICK, 12'd0, 12'd4095, 1, 0, 0, 0));
      req_valid <= 1'b0;
      wait_drained();

      // Random phases across settings, extremes among them.
      configure(16'd4095, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1023);
      run_phase(110, 1'b0, 1'b0);
      configure(16'(TRIP_HIGH_RST), 16'(TRIP_LOW_RST), 16'(CURRENT_ALPHA_RST),
                16'(AUX_ALPHA_RST), 16'(AUX_SCALE_RST));
      run_phase(110, 1'b1, 1'b1);
      configure_random();
      run_phase(110, 1'b0, 1'b0);
      configure(16'd2000, 16'd2000, 16'd1, 16'd32768, 16'd0);
      run_phase(110, 1'b1, 1'b0);
      configure_random();
      run_phase(110, 1'b1, 1'b1);
      configure_random();
      run_phase(150, 1'b0, 1'b0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
